// ===== hw/rtl/bbc_pkg.sv =====
`timescale 1ns / 1ps
package bbc_pkg;

  localparam int OP_W     = 2;
  localparam int DEV_W    = 8;
  localparam int BLK_W    = 32;
  localparam int SLOT_W   = 5;
  localparam int STAMP_W  = 32;
  localparam int CNT_W    = 8;
  localparam int STATUS_W = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

  typedef enum logic [OP_W-1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_NOFREE = 2'd1,
    STAT_UNDER  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_GET_WR,
    S_SLOT_RD,
    S_SLOT_WR,
    S_SLOT_NOP
  } state_t;

  typedef struct packed {
    logic               cv;
    logic [DEV_W-1:0]   dev;
    logic [BLK_W-1:0]   blk;
    logic [CNT_W-1:0]   cnt;
    logic [STAMP_W-1:0] stamp;
  } ent_t;

  typedef struct packed {
    logic hit;
    logic free;
  } scan_flags_t;

endpackage

// ===== hw/rtl/bbc_store.sv =====
`timescale 1ns / 1ps
module bbc_store
  import bbc_pkg::*;
#(
  parameter int SLOTS = 32,
  parameter int IDX_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output ent_t             rd_ent,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  ent_t             wr_ent
);

  ent_t             mem [SLOTS];
  ent_t             rd_data_r;
  logic [SLOTS-1:0] vld_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_ent;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // An entry never written since reset reads back as all zeros.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_ent = rd_vld_r ? rd_data_r : '0;

endmodule

// ===== hw/rtl/bbc_scan.sv =====
`timescale 1ns / 1ps
module bbc_scan
  import bbc_pkg::*;
#(
  parameter int IDX_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic             smp_vld,
  input  logic [IDX_W-1:0] smp_idx,
  input  ent_t             smp_ent,
  input  logic [DEV_W-1:0] key_dev,
  input  logic [BLK_W-1:0] key_blk,
  output scan_flags_t      flags,
  output logic [IDX_W-1:0] hit_idx,
  output ent_t             hit_ent,
  output logic [IDX_W-1:0] lru_idx
);

  scan_flags_t        flags_r;
  logic [IDX_W-1:0]   hit_idx_r;
  ent_t               hit_ent_r;
  logic [IDX_W-1:0]   lru_idx_r;
  logic [STAMP_W-1:0] lru_stamp_r;
  logic               tag_eq;
  logic               take_hit;
  logic               take_lru;

  assign tag_eq   = (smp_ent.dev == key_dev) && (smp_ent.blk == key_blk);
  assign take_hit = smp_vld && tag_eq && !flags_r.hit;
  // Strictly older only, so the lowest index wins a tie.
  assign take_lru = smp_vld && (smp_ent.cnt == '0) &&
                    (!flags_r.free || (smp_ent.stamp < lru_stamp_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (clr) begin
      flags_r <= '0;
    end else begin
      if (take_hit) begin
        flags_r.hit <= 1'b1;
      end
      if (take_lru) begin
        flags_r.free <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_hit) begin
      hit_idx_r <= smp_idx;
      hit_ent_r <= smp_ent;
    end
    if (take_lru) begin
      lru_idx_r   <= smp_idx;
      lru_stamp_r <= smp_ent.stamp;
    end
  end

  assign flags   = flags_r;
  assign hit_idx = hit_idx_r;
  assign hit_ent = hit_ent_r;
  assign lru_idx = lru_idx_r;

endmodule

// ===== hw/rtl/block_buffer_cache_lru_unit.sv =====
`timescale 1ns / 1ps
// Channel  Ports                                                Direction
// in       in_valid/in_ready, in_op, in_device, in_block_number,  input
//          in_slot_in, in_now
// out      out_valid/out_ready, out_slot_out, out_hit,           output
//          out_needs_read, out_status
//
// A get scans the slot store, reading one entry per cycle
// through its single read port and a shared tag and stamp comparator.
// Release, pin and unpin read then update their slot, if in range.
// The input is not ready until the result beat of the current item has been
// loaded into the output register. Reset clears every slot to zero at once.
module block_buffer_cache_lru_unit
  import bbc_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_op,
  input  logic [DEV_W-1:0]    in_device,
  input  logic [BLK_W-1:0]    in_block_number,
  input  logic [SLOT_W-1:0]   in_slot_in,
  input  logic [STAMP_W-1:0]  in_now,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SLOT_W-1:0]   out_slot_out,
  output logic                out_hit,
  output logic                out_needs_read,
  output logic [STATUS_W-1:0] out_status
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  state_t               state_r;
  state_t               state_nxt;
  op_t                  op_r;
  logic [DEV_W-1:0]     dev_r;
  logic [BLK_W-1:0]     blk_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [STAMP_W-1:0]   now_r;
  logic [IDX_W-1:0]     scan_cnt_r;
  logic                 smp_vld_r;
  logic [IDX_W-1:0]     smp_idx_r;

  logic                 out_valid_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic                 out_hit_r;
  logic                 out_rd_r;
  status_t              out_status_r;

  logic                 accept;
  logic                 out_free;
  logic                 in_oor;
  logic                 fin;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  ent_t                 rd_ent;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  ent_t                 wr_ent;
  logic [SLOT_W-1:0]    res_slot;
  logic                 res_hit;
  logic                 res_rd;
  status_t              res_status;

  scan_flags_t          flags;
  logic [IDX_W-1:0]     hit_idx;
  ent_t                 hit_ent;
  logic [IDX_W-1:0]     lru_idx;

  logic [EXT_W-1:0]     slot_ext;
  logic [EXT_W-1:0]     hit_ext;
  logic [EXT_W-1:0]     lru_ext;
  logic [IDX_W-1:0]     slot_idx;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign in_oor   = (32'(in_slot_in) >= SLOTS);

  assign slot_ext = EXT_W'(slot_r);
  assign slot_idx = slot_ext[IDX_W-1:0];
  assign hit_ext  = EXT_W'(hit_idx);
  assign lru_ext  = EXT_W'(lru_idx);

  bbc_store #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_ent  (rd_ent),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_ent  (wr_ent)
  );

  bbc_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (accept),
    .smp_vld (smp_vld_r),
    .smp_idx (smp_idx_r),
    .smp_ent (rd_ent),
    .key_dev (dev_r),
    .key_blk (blk_r),
    .flags   (flags),
    .hit_idx (hit_idx),
    .hit_ent (hit_ent),
    .lru_idx (lru_idx)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (op_t'(in_op) == OP_GET) begin
            state_nxt = S_SCAN;
          end else if (in_oor) begin
            state_nxt = S_SLOT_NOP;
          end else begin
            state_nxt = S_SLOT_RD;
          end
        end
      end
      S_SCAN: begin
        if (scan_cnt_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:   state_nxt = S_GET_WR;
      S_SLOT_RD: state_nxt = S_SLOT_WR;
      S_GET_WR, S_SLOT_WR, S_SLOT_NOP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    fin        = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = scan_cnt_r;
    wr_en      = 1'b0;
    wr_addr    = slot_idx;
    wr_ent     = rd_ent;
    res_slot   = slot_r;
    res_hit    = 1'b0;
    res_rd     = 1'b0;
    res_status = STAT_OK;
    case (state_r)
      S_SCAN: begin
        rd_en = 1'b1;
      end
      S_SLOT_RD: begin
        rd_en   = 1'b1;
        rd_addr = slot_idx;
      end
      S_GET_WR: begin
        fin = out_free;
        if (flags.hit) begin
          wr_en        = fin;
          wr_addr      = hit_idx;
          wr_ent       = hit_ent;
          wr_ent.cnt   = (hit_ent.cnt == COUNT_MAX) ? hit_ent.cnt : hit_ent.cnt + 8'd1;
          wr_ent.stamp = now_r;
          wr_ent.cv    = 1'b1;
          res_slot     = hit_ext[SLOT_W-1:0];
          res_hit      = 1'b1;
          res_rd       = !hit_ent.cv;
        end else if (flags.free) begin
          wr_en        = fin;
          wr_addr      = lru_idx;
          wr_ent.cv    = 1'b1;
          wr_ent.dev   = dev_r;
          wr_ent.blk   = blk_r;
          wr_ent.cnt   = 8'd1;
          wr_ent.stamp = now_r;
          res_slot     = lru_ext[SLOT_W-1:0];
          res_rd       = 1'b1;
        end else begin
          res_slot   = '0;
          res_status = STAT_NOFREE;
        end
      end
      S_SLOT_WR: begin
        fin = out_free;
        if (op_r == OP_PIN) begin
          wr_en      = fin;
          wr_ent.cnt = (rd_ent.cnt == COUNT_MAX) ? rd_ent.cnt : rd_ent.cnt + 8'd1;
        end else if (rd_ent.cnt == '0) begin
          res_status = STAT_UNDER;
        end else begin
          wr_en      = fin;
          wr_ent.cnt = rd_ent.cnt - 8'd1;
        end
      end
      S_SLOT_NOP: begin
        fin = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_cnt_r  <= '0;
      smp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      smp_vld_r <= (state_r == S_SCAN);
      if (accept) begin
        scan_cnt_r <= '0;
      end else if (state_r == S_SCAN) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    smp_idx_r <= scan_cnt_r;
    if (accept) begin
      op_r   <= op_t'(in_op);
      dev_r  <= in_device;
      blk_r  <= in_block_number;
      slot_r <= in_slot_in;
      now_r  <= in_now;
    end
    if (fin) begin
      out_slot_r   <= res_slot;
      out_hit_r    <= res_hit;
      out_rd_r     <= res_rd;
      out_status_r <= res_status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_slot_out   = out_slot_r;
  assign out_hit        = out_hit_r;
  assign out_needs_read = out_rd_r;
  assign out_status     = out_status_r;

endmodule
